// ===== src/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the biquad filter unit: coefficient format,
// register indexes, and the command group from controller to datapath.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 14;

    localparam int COEF_BITS    = 18;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FEED_ZERO = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEED_ONE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEED_TWO  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_ONE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_TWO  = 3'd4;

    typedef enum logic [2:0] {
        MUL_A1W1 = 3'd0,
        MUL_A2W2 = 3'd1,
        MUL_B0W  = 3'd2,
        MUL_B1W1 = 3'd3,
        MUL_B2W2 = 3'd4
    } t_mul_sel;

    typedef enum logic {
        ACC_ADD = 1'b0,
        ACC_SUB = 1'b1
    } t_acc_op;

    typedef struct packed {
        logic     acc_init_fb;
        logic     acc_init_ff;
        logic     acc_wr;
        t_acc_op  acc_op;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     take_w;
        logic     take_y;
    } t_dp_cmd;

endpackage

// ===== src/biq_ctrl.sv =====
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer for one sample: two feedback products, w, three feedforward
// products, y. Drives the datapath through a command group.
// ----------------------------------------------------------------------------
module biq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_busy,
    output biq_pkg::t_dp_cmd o_cmd
);
    import biq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FB_M1 = 8'b0000_0010,
        S_FB_M2 = 8'b0000_0100,
        S_W     = 8'b0000_1000,
        S_FF_M0 = 8'b0001_0000,
        S_FF_M1 = 8'b0010_0000,
        S_FF_M2 = 8'b0100_0000,
        S_Y     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.acc_init_fb = 1'b1;
                    n_state           = S_FB_M1;
                end
            end
            S_FB_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_A1W1;
                n_state       = S_FB_M2;
            end
            S_FB_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_A2W2;
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.acc_wr  = 1'b1;
                n_state       = S_W;
            end
            S_W: begin
                o_cmd.acc_op      = ACC_SUB;
                o_cmd.take_w      = 1'b1;
                o_cmd.acc_init_ff = 1'b1;
                n_state           = S_FF_M0;
            end
            S_FF_M0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B0W;
                n_state       = S_FF_M1;
            end
            S_FF_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B1W1;
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.acc_wr  = 1'b1;
                n_state       = S_FF_M2;
            end
            S_FF_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_B2W2;
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.acc_wr  = 1'b1;
                n_state       = S_Y;
            end
            S_Y: begin
                o_cmd.acc_op = ACC_ADD;
                if (!i_out_busy) begin
                    o_cmd.take_y = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/biq_datapath.sv =====
// ----------------------------------------------------------------------------
// biq_datapath
// Coefficient registers, delay line, one shared multiplier with a product
// register, accumulator with rounding and saturation, output register.
// ----------------------------------------------------------------------------
module biq_datapath #(
    parameter int SAMPLE_BITS    = biq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  biq_pkg::t_dp_cmd                  i_cmd,
    output logic                              o_out_busy,
    input  logic                              i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [biq_pkg::COEF_BITS-1:0]     i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    output logic                              o_clipped
);
    import biq_pkg::*;

    localparam int W_BITS = SAMPLE_BITS + 8;
    localparam int P_BITS = COEF_BITS + W_BITS;
    localparam int ACC_A  = P_BITS;
    localparam int ACC_B  = SAMPLE_BITS + COEF_FRAC_BITS + 1;
    localparam int ACC_W  = ((ACC_A > ACC_B) ? ACC_A : ACC_B) + 3;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_UNITY =
        (COEF_FRAC_BITS >= COEF_BITS - 1) ? COEF_MAX : COEF_BITS'(64'd1 << COEF_FRAC_BITS);

    logic signed [COEF_BITS-1:0] r_feed_zero, r_feed_one, r_feed_two;
    logic signed [COEF_BITS-1:0] r_back_one, r_back_two;
    logic signed [W_BITS-1:0]    r_w1, r_w2, r_w;
    logic                        r_w_hit;
    logic signed [P_BITS-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                        r_clipped;

    logic signed [COEF_BITS-1:0] mul_coef;
    logic signed [W_BITS-1:0]    mul_data;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [ACC_W-1:0]     acc_rnd;
    logic                        w_ovf;
    logic                        y_ovf;
    logic signed [W_BITS-1:0]    w_val;
    logic signed [SAMPLE_BITS-1:0] y_val;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_zero <= COEF_UNITY;
            r_feed_one  <= '0;
            r_feed_two  <= '0;
            r_back_one  <= '0;
            r_back_two  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FEED_ZERO: r_feed_zero <= i_cfg_data;
                REG_FEED_ONE:  r_feed_one  <= i_cfg_data;
                REG_FEED_TWO:  r_feed_two  <= i_cfg_data;
                REG_BACK_ONE:  r_back_one  <= i_cfg_data;
                REG_BACK_TWO:  r_back_two  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_A1W1: begin
                mul_coef = r_back_one;
                mul_data = r_w1;
            end
            MUL_A2W2: begin
                mul_coef = r_back_two;
                mul_data = r_w2;
            end
            MUL_B0W: begin
                mul_coef = r_feed_zero;
                mul_data = r_w;
            end
            MUL_B1W1: begin
                mul_coef = r_feed_one;
                mul_data = r_w1;
            end
            MUL_B2W2: begin
                mul_coef = r_feed_two;
                mul_data = r_w2;
            end
            default: begin
                mul_coef = '0;
                mul_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_coef * mul_data;
        end
    end

    assign prod_ext = ACC_W'(r_prod);
    assign acc_sum  = (i_cmd.acc_op == ACC_SUB) ? (r_acc - prod_ext) : (r_acc + prod_ext);
    // round to nearest, ties up: RND was added at accumulator init
    assign acc_rnd  = acc_sum >>> COEF_FRAC_BITS;

    assign w_ovf = !((&acc_rnd[ACC_W-1:W_BITS-1]) || !(|acc_rnd[ACC_W-1:W_BITS-1]));
    assign y_ovf = !((&acc_rnd[ACC_W-1:SAMPLE_BITS-1]) || !(|acc_rnd[ACC_W-1:SAMPLE_BITS-1]));
    assign w_val = w_ovf ? {acc_rnd[ACC_W-1], {(W_BITS-1){~acc_rnd[ACC_W-1]}}}
                         : acc_rnd[W_BITS-1:0];
    assign y_val = y_ovf ? {acc_rnd[ACC_W-1], {(SAMPLE_BITS-1){~acc_rnd[ACC_W-1]}}}
                         : acc_rnd[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init_fb) begin
            r_acc <= (ACC_W'(i_sample_in) <<< COEF_FRAC_BITS) + RND;
        end else if (i_cmd.acc_init_ff) begin
            r_acc <= RND;
        end else if (i_cmd.acc_wr) begin
            r_acc <= acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_w) begin
            r_w     <= w_val;
            r_w_hit <= w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_cmd.take_y) begin
            r_w2 <= r_w1;
            r_w1 <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_y) begin
            r_sample_out <= y_val;
            r_clipped    <= r_w_hit | y_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.take_y) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_busy   = r_out_valid & i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

// ===== src/biquad_iir_filter_unit.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Second-order IIR section, Direct Form II, fixed point, with saturation
// of w and y and a clip flag.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_stall     | i_sample_in
//  output   | out       | o_out_valid / i_out_stall   | o_sample_out, o_clipped
//  config   | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  Per sample, from request to result, five products share a
//  single 18 x (SAMPLE_BITS+8) multiplier, one product per cycle.
//  The next sample is taken as soon as the result is in the output register.
//  If the output register is still full and stalled, the sequencer holds.
//  Reset clears the delay line, sets b0 to unity and the other coefficients
//  to zero. Config writes are always ready.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit #(
    parameter int SAMPLE_BITS    = biq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]    o_sample_out,
    output logic                             o_clipped,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [biq_pkg::COEF_BITS-1:0]    i_cfg_data
);
    import biq_pkg::*;

    t_dp_cmd cmd;
    logic    out_busy;

    assign o_cfg_ready = 1'b1;

    biq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_busy (out_busy),
        .o_cmd      (cmd)
    );

    biq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_out_busy   (out_busy),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("sequence ended without a result");

endmodule
